/* rtl/gcp_pkg.sv */
// Shared constants, types and log2 tables for the gamma correction pipeline.
package gcp_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int LANES          = 3;
    localparam int DATA_W         = LANES * COMPONENT_BITS;
    localparam int EXP_W          = 16;
    localparam int EXP_FRAC_DEF   = 12;
    localparam logic [EXP_W-1:0] EXP_RESET = 16'd4096;

    localparam int LOG_FRAC  = 56;
    localparam int MANT_FRAC = 60;
    localparam int LOG_W     = 60;
    localparam int PP_SPLIT  = 32;
    localparam int PROD_W    = EXP_W + LOG_W;
    localparam int LANE_ST   = 3 + COMPONENT_BITS;
    localparam int TAB_N     = 2 ** COMPONENT_BITS;
    localparam int CMAX      = TAB_N - 1;

    typedef logic [LOG_W-1:0] t_log;
    typedef logic [TAB_N-1:0][LOG_W-1:0] t_log_tab;

    typedef struct packed {
        logic [LANE_ST-1:0] en;
        logic               last_vld;
    } t_lane_ctl;

    typedef struct packed {
        logic                      zero;
        logic [COMPONENT_BITS-1:0] k;
    } t_lane_res;

    function automatic t_log log2_fixed(input int unsigned n);
        logic [127:0] z;
        logic [127:0] sq;
        t_log res;
        int unsigned m;
        n = n & 511;
        if (n == 0) begin
            n = 1;
        end
        m = 0;
        while (m < 8 && (n >> (m + 1)) != 0) begin
            m++;
        end
        z   = 128'(n) << (MANT_FRAC - m);
        res = LOG_W'(m) << LOG_FRAC;
        for (int b = LOG_FRAC - 1; b >= 0; b--) begin
            sq = z * z;
            z  = sq >> MANT_FRAC;
            if (z >= (128'd2 << MANT_FRAC)) begin
                z      = z >> 1;
                res[b] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_log_tab gen_d_tab();
        t_log_tab t;
        t[0] = '0;
        for (int i = 1; i < TAB_N; i++) begin
            t[i] = log2_fixed(CMAX) - log2_fixed(i);
        end
        return t;
    endfunction

    function automatic t_log_tab gen_u_tab();
        t_log_tab t;
        t[0] = '1;
        for (int k = 1; k < TAB_N; k++) begin
            t[k] = log2_fixed(2 * CMAX) - log2_fixed(2 * k - 1);
        end
        return t;
    endfunction

    localparam t_log_tab D_TAB = gen_d_tab();
    localparam t_log_tab U_TAB = gen_u_tab();

endpackage

/* rtl/gcp_lane.sv */
// One component lane: log distance lookup, exponent multiply and bitwise threshold search.
module gcp_lane #(
    parameter int EXP_FRAC_BITS = gcp_pkg::EXP_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gcp_pkg::t_lane_ctl                 i_ctl,
    input  logic [gcp_pkg::COMPONENT_BITS-1:0] i_comp,
    input  logic [gcp_pkg::EXP_W-1:0]          i_exponent,
    output gcp_pkg::t_lane_res                 o_res
);

    localparam int CB     = gcp_pkg::COMPONENT_BITS;
    localparam int LOG_W  = gcp_pkg::LOG_W;
    localparam int SPLIT  = gcp_pkg::PP_SPLIT;
    localparam int PROD_W = gcp_pkg::PROD_W;
    localparam int PPL_W  = gcp_pkg::EXP_W + SPLIT;
    localparam int PPH_W  = gcp_pkg::EXP_W + LOG_W - SPLIT;
    localparam int T_W    = LOG_W + EXP_FRAC_BITS;
    localparam int CMP_W  = (PROD_W > T_W) ? PROD_W : T_W;

    logic [LOG_W-1:0]  r_d;
    logic              r_zero0;
    logic [PPL_W-1:0]  r_pp_lo;
    logic [PPH_W-1:0]  r_pp_hi;
    logic              r_zero1;
    logic [PROD_W-1:0] r_p;
    logic              r_zero2;
    logic [CB-1:0]     r_sk [CB];
    logic [PROD_W-1:0] r_sp [CB];
    logic              r_sz [CB];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_zero0 <= (i_comp == '0);
            r_d     <= (i_comp == '0) ? '0 : gcp_pkg::D_TAB[i_comp];
        end
        if (i_ctl.en[1]) begin
            r_zero1 <= r_zero0;
            r_pp_lo <= PPL_W'(i_exponent) * PPL_W'(r_d[SPLIT-1:0]);
            r_pp_hi <= PPH_W'(i_exponent) * PPH_W'(r_d[LOG_W-1:SPLIT]);
        end
        if (i_ctl.en[2]) begin
            r_zero2 <= r_zero1;
            r_p     <= PROD_W'(r_pp_lo) + (PROD_W'(r_pp_hi) << SPLIT);
        end
    end

    for (genvar s = 0; s < CB; s++) begin : g_srch
        logic [CB-1:0]     k_in;
        logic [CB-1:0]     cand;
        logic [PROD_W-1:0] p_in;
        logic              z_in;
        logic [T_W-1:0]    thr;
        logic              ok;

        if (s == 0) begin : g_first
            assign k_in = '0;
            assign p_in = r_p;
            assign z_in = r_zero2;
        end else begin : g_next
            assign k_in = r_sk[s-1];
            assign p_in = r_sp[s-1];
            assign z_in = r_sz[s-1];
        end

        assign cand = k_in | (CB'(1) << (CB - 1 - s));
        assign thr  = T_W'(gcp_pkg::U_TAB[cand]) << EXP_FRAC_BITS;
        assign ok   = CMP_W'(p_in) <= CMP_W'(thr);

        always_ff @(posedge i_clk) begin
            if (i_ctl.en[3+s]) begin
                r_sk[s] <= ok ? cand : k_in;
                r_sp[s] <= p_in;
                r_sz[s] <= z_in;
            end
        end
    end

    assign o_res.zero = r_sz[CB-1];
    assign o_res.k    = r_sk[CB-1];

    a_zero_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.last_vld && r_sz[CB-1]) |-> (r_sk[CB-1] == '1))
        else $error("zero component did not reach the full threshold");

endmodule

/* rtl/gcp_merge.sv */
// Merge stage: applies the zero-component rule and registers the packed output beat.
module gcp_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  gcp_pkg::t_lane_res [gcp_pkg::LANES-1:0] i_res,
    input  logic                                   i_last,
    input  logic [gcp_pkg::EXP_W-1:0]              i_exponent,
    output logic                                   o_rdy,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [gcp_pkg::DATA_W-1:0]             o_m_tdata,
    output logic                                   o_m_tlast
);

    localparam int CB = gcp_pkg::COMPONENT_BITS;

    logic                        r_valid;
    logic [gcp_pkg::DATA_W-1:0]  r_data;
    logic                        r_last;
    logic [gcp_pkg::DATA_W-1:0]  n_data;

    assign o_rdy = !r_valid || i_m_tready;

    always_comb begin
        for (int l = 0; l < gcp_pkg::LANES; l++) begin
            n_data[l*CB +: CB] = (i_res[l].zero && i_exponent != '0) ? '0 : i_res[l].k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rdy) begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
            r_last <= i_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

/* rtl/gamma_correct_pixel.sv */
// Top level of the power-law gamma correction pipeline for RGB pixels.
//
//  channel | direction | handshake                 | payload
//  s       | in        | i_s_tvalid / o_s_tready   | i_s_tdata (R,G,B), i_s_tlast
//  m       | out       | o_m_tvalid / i_m_tready   | o_m_tdata (R,G,B), o_m_tlast
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (exponent, Q4.12)
//
// One pixel is accepted per cycle while o_s_tready is high; a beat passes through eleven
// lane stages (lookup, two multiply stages, eight search steps) and the output register
// before it is offered on the output. Reset clears the stage valid bits and sets the
// exponent to identity. A stalled output holds its beat; bubbles ahead of it still fill.
// A configuration beat is taken only while the pipeline is empty and no pixel is offered.
module gamma_correct_pixel #(
    parameter int EXP_FRAC_BITS = gcp_pkg::EXP_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [gcp_pkg::DATA_W-1:0]    i_s_tdata,   // red, green, blue
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [gcp_pkg::DATA_W-1:0]    o_m_tdata,   // red, green, blue
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gcp_pkg::EXP_W-1:0]     i_cfg_data
);

    localparam int NS = gcp_pkg::LANE_ST;
    localparam int CB = gcp_pkg::COMPONENT_BITS;

    logic [gcp_pkg::EXP_W-1:0]              r_exponent;
    logic [NS-1:0]                          r_v;
    logic [NS-1:0]                          r_last;
    logic [NS-1:0]                          w_rdy;
    logic                                   w_merge_rdy;
    gcp_pkg::t_lane_ctl                     w_ctl;
    gcp_pkg::t_lane_res [gcp_pkg::LANES-1:0] w_res;

    assign o_cfg_ready = !(|r_v) && !o_m_tvalid && !i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= gcp_pkg::EXP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exponent <= i_cfg_data;
        end
    end

    assign w_rdy[NS-1] = !r_v[NS-1] || w_merge_rdy;
    for (genvar i = 0; i < NS - 1; i++) begin : g_rdy
        assign w_rdy[i] = !r_v[i] || w_rdy[i+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_last[0] <= i_s_tlast;
        end
        for (int i = 1; i < NS; i++) begin
            if (w_rdy[i]) begin
                r_last[i] <= r_last[i-1];
            end
        end
    end

    assign o_s_tready     = w_rdy[0];
    assign w_ctl.en       = w_rdy;
    assign w_ctl.last_vld = r_v[NS-1];

    for (genvar l = 0; l < gcp_pkg::LANES; l++) begin : g_lane
        gcp_lane #(
            .EXP_FRAC_BITS(EXP_FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_comp     (i_s_tdata[l*CB +: CB]),
            .i_exponent (r_exponent),
            .o_res      (w_res[l])
        );
    end

    gcp_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_v[NS-1]),
        .i_res      (w_res),
        .i_last     (r_last[NS-1]),
        .i_exponent (r_exponent),
        .o_rdy      (w_merge_rdy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    a_exp_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_exponent == gcp_pkg::EXP_RESET))
        else $error("exponent not at identity after reset");

    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rdy[0] |=> (r_v[0] == $past(i_s_tvalid)))
        else $error("first stage valid does not follow the accepted beat");

    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !w_merge_rdy) |=> r_v[NS-1])
        else $error("last lane stage dropped a beat while the output stalled");

endmodule
